FILE: rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg: shared types and constants of the LZSS window decompressor
// Window geometry, field widths and the command word that the stream parser
// hands to the copy engine.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  // History store depth and address width
  localparam int WINDOW_DEPTH = 8192;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 24;  // declared output size
  localparam int BACK_W   = 13;  // match distance + 3, up to 4098
  localparam int LEN_W    = 5;   // match length + 3, up to 18
  localparam int SEEN_W   = 13;  // bytes output since header, saturating

  localparam logic [SEEN_W-1:0] WRITTEN_MAX = {SEEN_W{1'b1}};
  localparam logic [BACK_W-1:0] MATCH_BIAS  = BACK_W'(3);

  // One unit of work for the copy engine
  typedef struct packed {
    logic              valid;
    logic              lit;       // 1: literal, 0: match copy
    logic [BYTE_W-1:0] lit_byte;
    logic [BACK_W-1:0] back;
    logic [LEN_W-1:0]  count;
    logic              err;
    logic              done;      // stream size reached after this word
  } lzwd_cmd_t;

endpackage

FILE: rtl/lzwd_chan_if.sv
// ----------------------------------------------------------------------------
// lzwd channel interfaces
// Valid/ready channels for compressed input words and decompressed output
// words.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
  logic                       valid;
  logic                       ready;
  logic [lzwd_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzwd_out_if;
  logic                       valid;
  logic                       ready;
  logic [lzwd_pkg::BYTE_W-1:0] out_byte;
  logic                       run_last;
  logic                       stream_done;
  logic                       format_error;

  modport source (output valid, output out_byte, output run_last,
                  output stream_done, output format_error, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input stream_done, input format_error, output ready);
endinterface

FILE: rtl/lzwd_ram.sv
// ----------------------------------------------------------------------------
// lzwd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and read with registered output held between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lzwd_parser.sv
// ----------------------------------------------------------------------------
// lzwd_parser: compressed stream parser
// Tracks header, flag bytes and match words, keeps the size count and turns
// each literal and each complete match word into a command for the copy engine.
// ----------------------------------------------------------------------------
module lzwd_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [lzwd_pkg::BYTE_W-1:0]  data,
  output lzwd_pkg::lzwd_cmd_t          cmd
);

  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_HDR2  = 3'd2;
  localparam logic [2:0] PH_BODY  = 3'd3;
  localparam logic [2:0] PH_MATCH = 3'd4;

  logic [2:0]                          phase_r, phase_nxt;
  logic [lzwd_pkg::COUNT_W-1:0]        rem_r, rem_nxt;
  logic [7:0]                          flags_r, flags_nxt;
  logic [3:0]                          left_r, left_nxt;
  logic [7:0]                          high_r, high_nxt;
  logic [lzwd_pkg::SEEN_W-1:0]         seen_r, seen_nxt;

  logic [lzwd_pkg::COUNT_W-1:0]        hdr_val;
  logic [lzwd_pkg::LEN_W-1:0]          len;
  logic [lzwd_pkg::BACK_W-1:0]         back;
  logic                                len_cut;
  logic [lzwd_pkg::LEN_W-1:0]          cnt;
  logic [lzwd_pkg::COUNT_W-1:0]        rem_after;
  logic [lzwd_pkg::SEEN_W:0]           seen_sum;
  logic [lzwd_pkg::SEEN_W-1:0]         seen_sat;

  // Decode match word and clip its length to the remaining count
  always_comb begin
    hdr_val   = {rem_r[15:0], data};
    len       = lzwd_pkg::LEN_W'(data[3:0]) + lzwd_pkg::LEN_W'(3);
    back      = lzwd_pkg::BACK_W'({high_r, data[7:4]}) + lzwd_pkg::MATCH_BIAS;
    len_cut   = lzwd_pkg::COUNT_W'(len) > rem_r;
    cnt       = len_cut ? lzwd_pkg::LEN_W'(rem_r) : len;
    seen_sum  = (lzwd_pkg::SEEN_W+1)'(seen_r) + (lzwd_pkg::SEEN_W+1)'(cnt);
    seen_sat  = (seen_sum > (lzwd_pkg::SEEN_W+1)'(lzwd_pkg::WRITTEN_MAX))
                ? lzwd_pkg::WRITTEN_MAX : seen_sum[lzwd_pkg::SEEN_W-1:0];
    rem_after = rem_r - lzwd_pkg::COUNT_W'(cnt);
  end

  // Parse one accepted word
  always_comb begin
    phase_nxt    = phase_r;
    rem_nxt      = rem_r;
    flags_nxt    = flags_r;
    left_nxt     = left_r;
    high_nxt     = high_r;
    seen_nxt     = seen_r;
    cmd          = '0;
    cmd.lit_byte = data;
    cmd.back     = back;
    cmd.count    = cnt;
    if (take) begin
      case (phase_r)
        PH_HDR1: begin
          rem_nxt   = hdr_val;
          phase_nxt = PH_HDR2;
        end
        PH_HDR2: begin
          rem_nxt   = hdr_val;
          flags_nxt = '0;
          left_nxt  = '0;
          seen_nxt  = '0;
          phase_nxt = (hdr_val == '0) ? PH_HDR0 : PH_BODY;
        end
        PH_BODY: begin
          if (left_r == '0) begin
            flags_nxt = data;
            left_nxt  = 4'd8;
          end else if (flags_r[7]) begin
            high_nxt  = data;
            phase_nxt = PH_MATCH;
          end else begin
            cmd.valid = 1'b1;
            cmd.lit   = 1'b1;
            rem_nxt   = rem_r - lzwd_pkg::COUNT_W'(1);
            seen_nxt  = (seen_r == lzwd_pkg::WRITTEN_MAX) ? seen_r
                        : seen_r + lzwd_pkg::SEEN_W'(1);
          end
        end
        PH_MATCH: begin
          cmd.valid = 1'b1;
          cmd.err   = len_cut || (back > lzwd_pkg::BACK_W'(seen_r));
          rem_nxt   = rem_after;
          seen_nxt  = seen_sat;
        end
        default: begin
          rem_nxt   = lzwd_pkg::COUNT_W'(data);
          phase_nxt = PH_HDR1;
        end
      endcase

      // Finish a literal or match: advance flags, close stream at zero
      if (cmd.valid) begin
        cmd.done  = (rem_nxt == '0);
        flags_nxt = {flags_r[6:0], 1'b0};
        left_nxt  = (left_r != '0) ? left_r - 4'd1 : left_r;
        if (cmd.done) begin
          phase_nxt = PH_HDR0;
          left_nxt  = '0;
          flags_nxt = '0;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      rem_r   <= '0;
      flags_r <= '0;
      left_r  <= '0;
      high_r  <= '0;
      seen_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      flags_r <= flags_nxt;
      left_r  <= left_nxt;
      high_r  <= high_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

FILE: rtl/lzwd_copy.sv
// ----------------------------------------------------------------------------
// lzwd_copy: history store and copy engine
// Writes literals into the history store, replays matches through its read
// port one byte a cycle while the output is free, drives the output register.
// ----------------------------------------------------------------------------
module lzwd_copy (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lzwd_pkg::lzwd_cmd_t  cmd,
  output logic                 cmd_ready,
  lzwd_out_if.source           out_ch
);

  localparam int AW = lzwd_pkg::ADDR_W;
  localparam logic [AW:0] DEPTH_X = (AW+1)'(lzwd_pkg::WINDOW_DEPTH);

  logic [AW-1:0]                wp_r, wp_nxt;
  logic [AW-1:0]                src_r, src_nxt;
  logic [lzwd_pkg::LEN_W-1:0]   issue_left_r, issue_left_nxt;
  logic                         rd_pend_r, rd_pend_nxt;
  logic                         err_r, err_nxt;
  logic                         done_r, done_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [lzwd_pkg::BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_done_r, out_done_nxt;
  logic                         out_err_r, out_err_nxt;

  logic                         out_free;
  logic                         consume;
  logic                         issue;
  logic                         lit_in;
  logic                         we;
  logic [lzwd_pkg::BYTE_W-1:0]  wdata;
  logic [lzwd_pkg::BYTE_W-1:0]  rdata;
  logic [AW:0]                  back_x;
  logic [AW:0]                  wp_x;
  logic [AW-1:0]                src_start;

  // Handshake and pipeline control
  assign out_free  = !out_valid_r || out_ch.ready;
  assign consume   = rd_pend_r && out_free;
  assign issue     = (issue_left_r != '0) && (!rd_pend_r || consume);
  assign lit_in    = cmd.valid && cmd.lit;
  assign cmd_ready = (issue_left_r == '0) && !rd_pend_r && out_free;
  assign we        = consume || lit_in;
  assign wdata     = consume ? rdata : cmd.lit_byte;

  // Match source address, wrapped into the window
  always_comb begin
    back_x    = (AW+1)'(cmd.back);
    wp_x      = (AW+1)'(wp_r);
    src_start = (wp_x >= back_x) ? AW'(wp_x - back_x) : AW'(wp_x + DEPTH_X - back_x);
  end

  lzwd_ram #(
    .WIDTH (lzwd_pkg::BYTE_W),
    .DEPTH (lzwd_pkg::WINDOW_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (wp_r),
    .wdata (wdata),
    .re    (issue),
    .raddr (src_r),
    .rdata (rdata)
  );

  // Next-state logic: start matches, advance pointers, load output word
  always_comb begin
    wp_nxt         = wp_r;
    src_nxt        = src_r;
    issue_left_nxt = issue_left_r;
    err_nxt        = err_r;
    done_nxt       = done_r;
    rd_pend_nxt    = issue ? 1'b1 : (consume ? 1'b0 : rd_pend_r);
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    out_err_nxt    = out_err_r;

    if (we) begin
      wp_nxt        = (wp_r == AW'(lzwd_pkg::WINDOW_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      out_valid_nxt = 1'b1;
      out_byte_nxt  = wdata;
    end
    if (lit_in) begin
      out_last_nxt = 1'b1;
      out_done_nxt = cmd.done;
      out_err_nxt  = 1'b0;
    end
    if (consume) begin
      out_last_nxt = (issue_left_r == '0);
      out_done_nxt = (issue_left_r == '0) && done_r;
      out_err_nxt  = err_r;
    end
    if (issue) begin
      src_nxt        = (src_r == AW'(lzwd_pkg::WINDOW_DEPTH - 1)) ? '0 : src_r + AW'(1);
      issue_left_nxt = issue_left_r - lzwd_pkg::LEN_W'(1);
    end
    if (cmd.valid && !cmd.lit) begin
      src_nxt        = src_start;
      issue_left_nxt = cmd.count;
      err_nxt        = cmd.err;
      done_nxt       = cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      issue_left_r <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      wp_r         <= wp_nxt;
      issue_left_r <= issue_left_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    err_r      <= err_nxt;
    done_r     <= done_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.run_last     = out_last_r;
  assign out_ch.stream_done  = out_done_r;
  assign out_ch.format_error = out_err_r;

endmodule

FILE: rtl/lzwd_chan_top_note.sv
// ----------------------------------------------------------------------------
// lzwd_gate: input word gate
// Combines the input handshake with the copy engine's readiness and forms
// the accept strobe for the parser.
// ----------------------------------------------------------------------------
module lzwd_gate (
  input  logic       eng_ready,
  lzwd_in_if.sink    in_ch,
  output logic       take
);

  // Accept a word only when the engine can absorb its result
  assign in_ch.ready = eng_ready;
  assign take        = in_ch.valid && eng_ready;

endmodule

FILE: rtl/lzss_window_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_window_decompressor: byte-serial LZSS decompressor, 4K-reach window
// Input channel in_ch carries one compressed word per handshake: a 3-byte
// big-endian size header, then flag bytes (MSB first), literals and 2-byte
// match words (12-bit distance, 4-bit length). Output channel out_ch carries
// one decompressed word per handshake with run_last, stream_done and
// format_error.
// Header and flag words give no output. A literal appears on out_ch the
// cycle after it is accepted. A match of n bytes (n = length + 3, cut to
// the remaining size) is read from the history store's registered read
// port one byte per cycle while the receiver does not stall; each byte
// passes the read register before it enters the output register. The next
// input word is taken once the last byte has entered the output register
// and that register is free again.
// Reset (rst_n low, synchronous) returns the parser to the header, clears
// the size count and write pointer; history contents stay undefined.
// When the receiver stalls, the output register holds its word, the copy
// engine freezes with at most one read in flight, and in_ch.ready drops.
// ----------------------------------------------------------------------------
module lzss_window_decompressor (
  input  logic      clk,
  input  logic      rst_n,
  lzwd_in_if.sink   in_ch,
  lzwd_out_if.source out_ch
);

  logic                 eng_ready;
  logic                 take;
  lzwd_pkg::lzwd_cmd_t  cmd;

  lzwd_gate u_gate (
    .eng_ready (eng_ready),
    .in_ch     (in_ch),
    .take      (take)
  );

  lzwd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .data  (in_ch.in_byte),
    .cmd   (cmd)
  );

  lzwd_copy u_copy (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_ready (eng_ready),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/lzss_window_decompressor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decompressor_tb: self-checking bench for the LZSS decompressor
// Feeds compressed streams byte by byte and runs a bit-true stream parser and
// history window alongside the block. Every decompressed word is checked
// field by field against the oldest expected word. A short directed prologue
// is followed by random streams, with random idling on both channels, one
// long receiver hold-off and one full drain of the output.
// ----------------------------------------------------------------------------
module lzss_window_decompressor_tb;
  import lzwd_pkg::*;

  localparam int RUN_BIAS       = 3;     // match length field + 3 = bytes copied
  localparam int MAX_BACK       = 4098;  // 12-bit distance + 3
  localparam int RANDOM_ITEMS   = 500;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_BODY, PH_MATCH2
  } parse_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
    logic              err;
  } out_word_t;

  // Stream parser and history window; predicts decompressed words in order
  class unpack_predictor;
    parse_phase_e        phase;
    logic [COUNT_W-1:0]  size_left;
    logic [BYTE_W-1:0]   flag_reg;
    logic [3:0]          flags_avail;
    logic [BYTE_W-1:0]   match_hi;
    logic [ADDR_W-1:0]   wr_ptr;
    logic [SEEN_W-1:0]   seen;
    int                  filled;      // slots written since reset, saturating
    logic [BYTE_W-1:0]   history [WINDOW_DEPTH];
    out_word_t           due_words[$];
    int                  mismatch_count;

    function new();
      phase          = PH_HDR0;
      size_left      = '0;
      flag_reg       = '0;
      flags_avail    = '0;
      match_hi       = '0;
      wr_ptr         = '0;
      seen           = '0;
      filled         = 0;
      mismatch_count = 0;
    endfunction

    // Write one byte to the window and queue its expected word
    function void emit(logic [BYTE_W-1:0] b, logic err, logic is_last);
      out_word_t w;
      history[wr_ptr] = b;
      wr_ptr          = wr_ptr + 1'b1;
      if (seen != WRITTEN_MAX) seen = seen + 1'b1;
      if (filled < WINDOW_DEPTH) filled++;
      size_left = size_left - 1'b1;
      w.data = b;
      w.last = is_last;
      w.done = is_last && (size_left == '0);
      w.err  = err;
      due_words.push_back(w);
    endfunction

    // Consume one flag, return to the body or wait for a new header
    function void close_item();
      flag_reg = flag_reg << 1;
      if (flags_avail != 0) flags_avail = flags_avail - 1'b1;
      if (size_left == '0) begin
        phase       = PH_HDR0;
        flags_avail = '0;
        flag_reg    = '0;
      end else begin
        phase = PH_BODY;
      end
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      logic [15:0]       word;
      logic [BACK_W-1:0] back;
      int                cnt;
      logic              err;
      case (phase)
        PH_HDR1: begin
          size_left = {size_left[15:0], b};
          phase     = PH_HDR2;
        end
        PH_HDR2: begin
          size_left   = {size_left[15:0], b};
          flags_avail = '0;
          flag_reg    = '0;
          seen        = '0;
          phase       = (size_left == '0) ? PH_HDR0 : PH_BODY;
        end
        PH_BODY: begin
          if (flags_avail == 0) begin
            flag_reg    = b;
            flags_avail = 4'd8;
          end else if (flag_reg[7]) begin
            match_hi = b;
            phase    = PH_MATCH2;
          end else begin
            emit(b, 1'b0, 1'b1);
            close_item();
          end
        end
        PH_MATCH2: begin
          word = {match_hi, b};
          back = BACK_W'(word[15:4]) + MATCH_BIAS;
          cnt  = int'(word[3:0]) + RUN_BIAS;
          err  = 1'b0;
          // cut to what is still due
          if (cnt > int'(size_left)) begin
            cnt = int'(size_left);
            err = 1'b1;
          end
          // reaching before the start of this stream
          if (int'(back) > int'(seen)) err = 1'b1;
          for (int i = 0; i < cnt; i++)
            emit(history[wr_ptr - ADDR_W'(back)], err, i == cnt - 1);
          close_item();
        end
        default: begin
          size_left = {16'd0, b};
          phase     = PH_HDR1;
        end
      endcase
    endfunction

    function void check_word(logic [BYTE_W-1:0] data, logic last, logic done,
                             logic err);
      out_word_t w;
      if (due_words.size() == 0) begin
        $error("unexpected word: out_byte=%02h run_last=%0b", data, last);
        mismatch_count++;
        return;
      end
      w = due_words.pop_front();
      if (data !== w.data) begin
        $error("out_byte: expected %02h, actual %02h", w.data, data);
        mismatch_count++;
      end
      if (last !== w.last) begin
        $error("run_last: expected %0b, actual %0b", w.last, last);
        mismatch_count++;
      end
      if (done !== w.done) begin
        $error("stream_done: expected %0b, actual %0b", w.done, done);
        mismatch_count++;
      end
      if (err !== w.err) begin
        $error("format_error: expected %0b, actual %0b", w.err, err);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return due_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lzwd_in_if  in_ch ();
  lzwd_out_if out_ch ();

  lzss_window_decompressor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  unpack_predictor board = new();

  bit                 quiet    = 1'b0;  // no idling on either side
  bit                 hold_req = 1'b0;  // receiver holds off once
  logic [COUNT_W-1:0] next_size;
  logic [BYTE_W-1:0]  match_lo;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] pack_match(int back, int len_code);
    return 16'(((back - int'(MATCH_BIAS)) << 4) | (len_code & 'hF));
  endfunction

  // Pick the next compressed byte from the parser state; matches never reach
  // a window slot that was not written since reset
  function automatic logic [BYTE_W-1:0] next_stream_byte();
    int                r;
    int                reach;
    int                near_top;
    int                back;
    logic [15:0]       word;
    logic [BYTE_W-1:0] f;
    case (board.phase)
      PH_HDR0: begin
        r = $urandom_range(99);
        if (r < 8)       next_size = '0;
        else if (r < 60) next_size = COUNT_W'($urandom_range(48, 1));
        else if (r < 92) next_size = COUNT_W'($urandom_range(300, 49));
        else             next_size = COUNT_W'($urandom_range(1200, 301));
        return next_size[23:16];
      end
      PH_HDR1: return next_size[15:8];
      PH_HDR2: return next_size[7:0];
      PH_MATCH2: return match_lo;
      default: begin
        if (board.flags_avail == 0) begin
          f = BYTE_W'($urandom);
          // lead with literals until the window holds a minimal match
          if (board.filled < RUN_BIAS) f[7:5] = 3'b000;
          return f;
        end else if (board.flag_reg[7]) begin
          reach    = (board.filled > MAX_BACK) ? MAX_BACK : board.filled;
          near_top = (reach < 24) ? reach : 24;
          if ($urandom_range(99) < 70) back = $urandom_range(near_top, 3);
          else                         back = $urandom_range(reach, 3);
          word     = pack_match(back, $urandom_range(15));
          match_lo = word[7:0];
          return word[15:8];
        end
        return BYTE_W'($urandom);
      end
    endcase
  endfunction

  // Offer one word after a random gap; call at a falling edge
  task automatic drive_byte(input logic [BYTE_W-1:0] b);
    while (!quiet && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.take_byte(b);
    @(negedge clk);
  endtask

  task automatic send_header(input int size);
    drive_byte(BYTE_W'(size >> 16));
    drive_byte(BYTE_W'(size >> 8));
    drive_byte(BYTE_W'(size));
  endtask

  task automatic send_match(input int back, input int len_code);
    logic [15:0] word;
    word = pack_match(back, len_code);
    drive_byte(word[15:8]);
    drive_byte(word[7:0]);
  endtask

  // Lower valid and wait until every expected word has come out
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= quiet || ($urandom_range(99) >= 14);
    end
  end

  // Check every accepted output word
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_word(out_ch.out_byte, out_ch.run_last, out_ch.stream_done,
                       out_ch.format_error);
  end

  // Abort when neither channel moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty stream: header only
    send_header(0);

    // Six literals, a clean match, then a match cut to the two bytes left
    send_header(12);
    drive_byte(8'h03);
    drive_byte(8'h00);
    drive_byte(8'hFF);
    drive_byte(8'h55);
    drive_byte(8'hAA);
    drive_byte(8'h01);
    drive_byte(8'hFE);
    send_match(4, 1);
    send_match(3, 15);

    // Match into the previous stream, then one longer than what is left
    send_header(5);
    drive_byte(8'hFF);
    send_match(12, 0);
    send_match(3, 0);

    // Random streams
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 120) hold_req = 1'b1;
      if (n == 260) drain_outputs();
      quiet = (n >= 330) && (n < 430);
      drive_byte(next_stream_byte());
    end
    quiet = 1'b0;

    drain_outputs();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.mismatch_count == 0 && board.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lzwd_pkg.sv
rtl/lzwd_chan_if.sv
rtl/lzwd_ram.sv
rtl/lzwd_parser.sv
rtl/lzwd_copy.sv
rtl/lzwd_chan_top_note.sv
rtl/lzss_window_decompressor.sv
tb/lzss_window_decompressor_tb.sv
